// File: sv/kma_pkg.sv
// shared types and constants for the keyed minute bucket aggregator
// no dependencies

package kma_pkg;

  // table size and derived widths
  localparam int ENTRIES = 1024;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // field widths
  localparam int ID_W    = 32;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int COST_W  = 32;
  localparam int KEY_W   = ID_W + YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W;
  localparam int TOT_W   = 48;
  localparam int SLOT_W  = 10;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [TOT_W-1:0]  total_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // request handed from front to back
  typedef struct packed {
    key_t              key;
    logic [COST_W-1:0] cost;
  } req_t;

  // one result beat
  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic              created;
    logic              dropped;
    total_t            impressions_total;
    total_t            spend_total;
  } res_t;

  // search engine states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_MISS,
    S_EMIT
  } state_t;

endpackage

// File: sv/kma_front.sv
// front end: accepts events, packs the lookup key and queues requests
// depends on kma_pkg

module kma_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [kma_pkg::ID_W-1:0]       ad_id,
  input  logic [kma_pkg::YEAR_W-1:0]     bucket_year,
  input  logic [kma_pkg::MONTH_W-1:0]    bucket_month,
  input  logic [kma_pkg::DAY_W-1:0]      bucket_day,
  input  logic [kma_pkg::HOUR_W-1:0]     bucket_hour,
  input  logic [kma_pkg::MIN_W-1:0]      bucket_minute,
  input  logic [kma_pkg::COST_W-1:0]     spend,
  output logic                           req_valid,
  output kma_pkg::req_t                  req,
  input  logic                           req_pop
);

  kma_pkg::req_t req_mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  kma_pkg::req_t req_in;
  logic          do_push;
  logic          do_pop;

  // key layout: ad id on top, then year, month, day, hour, minute
  always_comb begin
    req_in.key  = {ad_id, bucket_year, bucket_month, bucket_day, bucket_hour, bucket_minute};
    req_in.cost = spend;
  end

  assign full      = (count == 2'd2);
  assign req_valid = (count != 2'd0);
  assign req       = req_mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = req_pop && req_valid;

  // request storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      req_mem[wr_ptr] <= req_in;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/kma_back.sv
// back end: linear key search over the table and read-modify-write of totals
// depends on kma_pkg

module kma_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  kma_pkg::req_t req,
  output logic          req_pop,
  output logic          res_push,
  output kma_pkg::res_t res,
  input  logic          res_full
);

  // table memories
  kma_pkg::key_t   key_mem [kma_pkg::ENTRIES];
  kma_pkg::total_t imp_mem [kma_pkg::ENTRIES];
  kma_pkg::total_t spd_mem [kma_pkg::ENTRIES];

  kma_pkg::state_t state;
  kma_pkg::state_t state_next;
  kma_pkg::cnt_t   fill_cnt;
  kma_pkg::cnt_t   scan_addr;
  kma_pkg::idx_t   cmp_idx;
  kma_pkg::idx_t   hit_idx;
  logic            cmp_vld;
  kma_pkg::key_t   key_q;
  logic [kma_pkg::COST_W-1:0] cost_q;
  kma_pkg::key_t   rd_key;
  kma_pkg::total_t rd_imp;
  kma_pkg::total_t rd_spd;
  kma_pkg::res_t   res_q;

  logic            hit;
  logic            tbl_full;
  logic            rd_en;
  logic            wr_en;
  kma_pkg::idx_t   wr_addr;
  kma_pkg::total_t wr_imp;
  kma_pkg::total_t wr_spd;
  logic            imp_bit;
  kma_pkg::total_t imp_sum;
  kma_pkg::total_t spd_sum;

  // saturating 48-bit add
  function automatic kma_pkg::total_t sat_add(kma_pkg::total_t a, kma_pkg::total_t b);
    logic [kma_pkg::TOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[kma_pkg::TOT_W] ? {kma_pkg::TOT_W{1'b1}} : s[kma_pkg::TOT_W-1:0];
  endfunction

  assign hit      = cmp_vld && (rd_key == key_q);
  assign tbl_full = (fill_cnt == kma_pkg::CNT_W'(kma_pkg::ENTRIES));
  assign imp_bit  = (cost_q == '0);
  assign imp_sum  = sat_add(rd_imp, kma_pkg::TOT_W'(imp_bit));
  assign spd_sum  = sat_add(rd_spd, kma_pkg::TOT_W'(cost_q));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      kma_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = kma_pkg::S_SCAN;
        end
      end
      kma_pkg::S_SCAN: begin
        if (hit) begin
          state_next = kma_pkg::S_UPD;
        end else if (scan_addr == fill_cnt) begin
          state_next = kma_pkg::S_MISS;
        end
      end
      kma_pkg::S_UPD:  state_next = kma_pkg::S_EMIT;
      kma_pkg::S_MISS: state_next = kma_pkg::S_EMIT;
      kma_pkg::S_EMIT: begin
        if (!res_full) begin
          state_next = kma_pkg::S_IDLE;
        end
      end
      default: state_next = kma_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_pop  = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    res_push = 1'b0;
    wr_addr  = hit_idx;
    wr_imp   = imp_sum;
    wr_spd   = spd_sum;
    case (state)
      kma_pkg::S_IDLE: req_pop = req_valid;
      kma_pkg::S_SCAN: rd_en = (scan_addr != fill_cnt) && !hit;
      kma_pkg::S_UPD:  wr_en = 1'b1;
      kma_pkg::S_MISS: begin
        wr_en   = !tbl_full;
        wr_addr = fill_cnt[kma_pkg::IDX_W-1:0];
        wr_imp  = kma_pkg::TOT_W'(imp_bit);
        wr_spd  = kma_pkg::TOT_W'(cost_q);
      end
      kma_pkg::S_EMIT: res_push = !res_full;
      default: req_pop = 1'b0;
    endcase
  end

  assign res = res_q;

  // table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= key_q;
      imp_mem[wr_addr] <= wr_imp;
      spd_mem[wr_addr] <= wr_spd;
    end
    if (rd_en) begin
      rd_key <= key_mem[scan_addr[kma_pkg::IDX_W-1:0]];
      rd_imp <= imp_mem[scan_addr[kma_pkg::IDX_W-1:0]];
      rd_spd <= spd_mem[scan_addr[kma_pkg::IDX_W-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= kma_pkg::S_IDLE;
      fill_cnt <= '0;
      cmp_vld  <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= rd_en;
      if (state == kma_pkg::S_MISS && !tbl_full) begin
        fill_cnt <= fill_cnt + 1'b1;
      end
    end
  end

  // request capture, scan address and result assembly
  always_ff @(posedge clk) begin
    if (req_pop) begin
      key_q     <= req.key;
      cost_q    <= req.cost;
      scan_addr <= '0;
    end
    if (rd_en) begin
      scan_addr <= scan_addr + 1'b1;
      cmp_idx   <= scan_addr[kma_pkg::IDX_W-1:0];
    end
    if (hit) begin
      hit_idx <= cmp_idx;
    end
    if (state == kma_pkg::S_UPD) begin
      res_q.slot_index        <= kma_pkg::SLOT_W'(hit_idx);
      res_q.created           <= 1'b0;
      res_q.dropped           <= 1'b0;
      res_q.impressions_total <= imp_sum;
      res_q.spend_total       <= spd_sum;
    end
    if (state == kma_pkg::S_MISS) begin
      if (tbl_full) begin
        res_q.slot_index        <= '0;
        res_q.created           <= 1'b0;
        res_q.dropped           <= 1'b1;
        res_q.impressions_total <= '0;
        res_q.spend_total       <= '0;
      end else begin
        res_q.slot_index        <= kma_pkg::SLOT_W'(fill_cnt);
        res_q.created           <= 1'b1;
        res_q.dropped           <= 1'b0;
        res_q.impressions_total <= kma_pkg::TOT_W'(imp_bit);
        res_q.spend_total       <= kma_pkg::TOT_W'(cost_q);
      end
    end
  end

`ifndef SYNTH
  // fill count never passes the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_cnt <= kma_pkg::CNT_W'(kma_pkg::ENTRIES))
    else $error("fill count above table size");

  // a matched entry lies inside the filled part
  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    state == kma_pkg::S_UPD |-> kma_pkg::CNT_W'(hit_idx) < fill_cnt)
    else $error("matched entry outside filled range");

  // a dropped beat only when the table is full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    res_push && res.dropped |-> tbl_full)
    else $error("drop while table has room");

  // an append grows the table by exactly one
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    state == kma_pkg::S_MISS && !tbl_full |=> fill_cnt == $past(fill_cnt) + 1'b1)
    else $error("append did not grow fill count");
`endif

endmodule

// File: sv/kma_res_q.sv
// result queue between the search engine and the result ports
// depends on kma_pkg

module kma_res_q (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_push,
  input  kma_pkg::res_t res_in,
  output logic          res_full,
  input  logic          pop,
  output logic          empty,
  output kma_pkg::res_t res_out
);

  kma_pkg::res_t res_mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign res_out  = res_mem[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  // result storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      res_mem[wr_ptr] <= res_in;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/keyed_minute_bucket_aggregator.sv
// top level: event queue, search engine and result queue
// depends on kma_pkg, kma_front, kma_back, kma_res_q

// Group-by aggregation table keyed by ad id and minute bucket. Each event is
// searched linearly against the filled entries through one read port of the
// table memories, one entry per cycle, stopping at the first match. A zero
// spend counts one impression; both totals saturate at 48 bits. A new key is
// appended at the end of the table; with the table full and no match the
// event is dropped and reported as such. Events queue in front of the search
// engine and results queue behind it, so both sides may stall freely. The
// table needs no clearing after reset.

module keyed_minute_bucket_aggregator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [kma_pkg::ID_W-1:0]       ad_id,
  input  logic [kma_pkg::YEAR_W-1:0]     bucket_year,
  input  logic [kma_pkg::MONTH_W-1:0]    bucket_month,
  input  logic [kma_pkg::DAY_W-1:0]      bucket_day,
  input  logic [kma_pkg::HOUR_W-1:0]     bucket_hour,
  input  logic [kma_pkg::MIN_W-1:0]      bucket_minute,
  input  logic [kma_pkg::COST_W-1:0]     spend,
  output logic                           empty,
  input  logic                           pop,
  output logic [kma_pkg::SLOT_W-1:0]     slot_index,
  output logic                           created,
  output logic                           dropped,
  output logic [kma_pkg::TOT_W-1:0]      impressions_total,
  output logic [kma_pkg::TOT_W-1:0]      spend_total
);

  logic          req_valid;
  kma_pkg::req_t req;
  logic          req_pop;
  logic          res_push;
  kma_pkg::res_t res;
  logic          res_full;
  kma_pkg::res_t res_out;

  // event intake
  kma_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .ad_id         (ad_id),
    .bucket_year   (bucket_year),
    .bucket_month  (bucket_month),
    .bucket_day    (bucket_day),
    .bucket_hour   (bucket_hour),
    .bucket_minute (bucket_minute),
    .spend         (spend),
    .req_valid     (req_valid),
    .req           (req),
    .req_pop       (req_pop)
  );

  // search and update
  kma_back u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  // result beats
  kma_res_q u_res_q (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .res_out  (res_out)
  );

  assign slot_index        = res_out.slot_index;
  assign created           = res_out.created;
  assign dropped           = res_out.dropped;
  assign impressions_total = res_out.impressions_total;
  assign spend_total       = res_out.spend_total;

endmodule

// File: tb/keyed_minute_bucket_aggregator_tb.sv
// self-checking testbench for the keyed minute bucket aggregator
// depends on kma_pkg and keyed_minute_bucket_aggregator; no files or arguments

`timescale 1ns / 100ps

module keyed_minute_bucket_aggregator_tb;

  localparam int MAX_GAP     = 12;
  localparam int MAX_STALL   = 8;
  localparam int HOLD_CYCLES = 3000;
  localparam int N_DIRECTED  = 16;
  localparam int N_RANDOM    = 540;
  localparam int N_TAIL      = 24;
  localparam int N_EVENTS    = N_DIRECTED + N_RANDOM + N_TAIL;
  localparam logic [kma_pkg::COST_W-1:0] MAX_COST = '1;

  // slowest correct run: every event scans a full table, plus sender gaps and
  // receiver stalls, plus the long receiver hold-off
  localparam longint SLOW_EVENT = kma_pkg::ENTRIES + 8 + MAX_GAP + MAX_STALL;
  localparam longint LIMIT = 3 * (longint'(N_EVENTS) * SLOW_EVENT + HOLD_CYCLES) + 20000;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             push = 1'b0;
  logic                             full;
  logic [kma_pkg::ID_W-1:0]         ad_id = '0;
  logic [kma_pkg::YEAR_W-1:0]       bucket_year = '0;
  logic [kma_pkg::MONTH_W-1:0]      bucket_month = '0;
  logic [kma_pkg::DAY_W-1:0]        bucket_day = '0;
  logic [kma_pkg::HOUR_W-1:0]       bucket_hour = '0;
  logic [kma_pkg::MIN_W-1:0]        bucket_minute = '0;
  logic [kma_pkg::COST_W-1:0]       spend = '0;
  logic                             empty;
  logic                             pop = 1'b0;
  logic [kma_pkg::SLOT_W-1:0]       slot_index;
  logic                             created;
  logic                             dropped;
  logic [kma_pkg::TOT_W-1:0]        impressions_total;
  logic [kma_pkg::TOT_W-1:0]        spend_total;

  keyed_minute_bucket_aggregator i_dut (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .ad_id             (ad_id),
    .bucket_year       (bucket_year),
    .bucket_month      (bucket_month),
    .bucket_day        (bucket_day),
    .bucket_hour       (bucket_hour),
    .bucket_minute     (bucket_minute),
    .spend             (spend),
    .empty             (empty),
    .pop               (pop),
    .slot_index        (slot_index),
    .created           (created),
    .dropped           (dropped),
    .impressions_total (impressions_total),
    .spend_total       (spend_total)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // stimulus bookkeeping
  kma_pkg::req_t   queued_events[$];
  kma_pkg::res_t   expected_updates[$];
  bit              known_key[kma_pkg::key_t];
  kma_pkg::key_t   key_pool[$];
  int              error_count = 0;
  longint          cycle_count = 0;
  logic            taken_q = 1'b0;
  logic            hold_arm = 1'b0;
  logic            holding = 1'b0;
  logic            hold_done = 1'b0;
  int              hold_left = 0;

  // shadow of the aggregation table
  kma_pkg::total_t shadow_imp[kma_pkg::ENTRIES];
  kma_pkg::total_t shadow_spend[kma_pkg::ENTRIES];
  int              slot_of[kma_pkg::key_t];
  int              fill_level = 0;

  task automatic flag_error(input string msg);
    $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic kma_pkg::total_t clamp_add48(input kma_pkg::total_t a,
                                                  input kma_pkg::total_t b);
    logic [kma_pkg::TOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[kma_pkg::TOT_W] ? '1 : s[kma_pkg::TOT_W-1:0];
  endfunction

  // update the shadow table with one event and return the result it produces
  function automatic kma_pkg::res_t bucket_accumulate(input kma_pkg::key_t k,
                                                      input logic [kma_pkg::COST_W-1:0] cost);
    kma_pkg::res_t   r;
    int              s;
    kma_pkg::total_t imp;
    r = '0;
    imp = (cost == '0) ? kma_pkg::total_t'(1) : '0;
    if (slot_of.exists(k)) begin
      s = slot_of[k];
      shadow_imp[s] = clamp_add48(shadow_imp[s], imp);
      shadow_spend[s] = clamp_add48(shadow_spend[s], kma_pkg::total_t'(cost));
      r.slot_index = kma_pkg::SLOT_W'(s);
      r.impressions_total = shadow_imp[s];
      r.spend_total = shadow_spend[s];
    end else if (fill_level >= kma_pkg::ENTRIES) begin
      r.dropped = 1'b1;
    end else begin
      s = fill_level;
      slot_of[k] = s;
      shadow_imp[s] = imp;
      shadow_spend[s] = kma_pkg::total_t'(cost);
      fill_level++;
      r.slot_index = kma_pkg::SLOT_W'(s);
      r.created = 1'b1;
      r.impressions_total = imp;
      r.spend_total = kma_pkg::total_t'(cost);
    end
    return r;
  endfunction

  // mostly calendar-legal buckets, sometimes raw bits
  function automatic kma_pkg::key_t fresh_key();
    if ($urandom_range(0, 3) == 0)
      return {32'($urandom), 32'($urandom)};
    return {kma_pkg::ID_W'($urandom), kma_pkg::YEAR_W'($urandom),
            kma_pkg::MONTH_W'($urandom_range(1, 12)),
            kma_pkg::DAY_W'($urandom_range(1, 31)),
            kma_pkg::HOUR_W'($urandom_range(0, 23)),
            kma_pkg::MIN_W'($urandom_range(0, 59))};
  endfunction

  function automatic kma_pkg::key_t unseen_key();
    kma_pkg::key_t k;
    k = fresh_key();
    while (known_key.exists(k))
      k = fresh_key();
    return k;
  endfunction

  function automatic logic [kma_pkg::COST_W-1:0] pick_cost();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30)
      return '0;
    if (r < 40)
      return MAX_COST;
    if (r < 55)
      return kma_pkg::COST_W'($urandom_range(1, 255));
    return kma_pkg::COST_W'($urandom);
  endfunction

  function automatic kma_pkg::key_t flip_one_bit(input kma_pkg::key_t k);
    return k ^ (kma_pkg::key_t'(1) << $urandom_range(0, kma_pkg::KEY_W - 1));
  endfunction

  task automatic queue_event(input kma_pkg::key_t k, input logic [kma_pkg::COST_W-1:0] cost);
    kma_pkg::req_t e;
    e.key = k;
    e.cost = cost;
    queued_events.push_back(e);
    if (!known_key.exists(k)) begin
      known_key[k] = 1'b1;
      key_pool.push_back(k);
    end
  endtask

  // sender pause: everything offered, accepted and answered
  task automatic wait_for_drain();
    while (queued_events.size() != 0 || push || expected_updates.size() != 0)
      @(posedge clk);
  endtask

  // input side: predict on every accepted beat
  always @(posedge clk) begin
    if (!rst && push && !full)
      expected_updates.push_back(bucket_accumulate(
        {ad_id, bucket_year, bucket_month, bucket_day, bucket_hour, bucket_minute}, spend));
    taken_q <= !rst && push && !full;
  end

  // output side: compare every accepted beat with the oldest prediction
  always @(posedge clk) begin : result_check
    kma_pkg::res_t want;
    if (!rst && pop && !empty) begin
      if (expected_updates.size() == 0) begin
        flag_error($sformatf("result beat with nothing pending: slot %0d", slot_index));
      end else begin
        want = expected_updates.pop_front();
        if (slot_index !== want.slot_index)
          flag_error($sformatf("slot_index %0d, want %0d", slot_index, want.slot_index));
        if (created !== want.created)
          flag_error($sformatf("created %b, want %b (slot %0d)", created, want.created,
                               want.slot_index));
        if (dropped !== want.dropped)
          flag_error($sformatf("dropped %b, want %b (slot %0d)", dropped, want.dropped,
                               want.slot_index));
        if (impressions_total !== want.impressions_total)
          flag_error($sformatf("impressions_total %0d, want %0d (slot %0d)",
                               impressions_total, want.impressions_total, want.slot_index));
        if (spend_total !== want.spend_total)
          flag_error($sformatf("spend_total %0d, want %0d (slot %0d)",
                               spend_total, want.spend_total, want.slot_index));
      end
    end
  end

  // event driver: bursts of random length with random gaps
  always @(negedge clk) begin : drive_events
    kma_pkg::req_t nxt;
    int            burst_left;
    int            gap_left;
    if (rst) begin
      push <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else if (!push || taken_q) begin
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (queued_events.size() != 0) begin
        nxt = queued_events.pop_front();
        {ad_id, bucket_year, bucket_month, bucket_day, bucket_hour, bucket_minute} <= nxt.key;
        spend <= nxt.cost;
        push <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
        end else begin
          burst_left--;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // one long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_arm && !hold_done && !holding) begin
      holding <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (holding) begin
      if (hold_left == 0) begin
        holding <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // receiver: alternating runs of pops and stalls
  always @(negedge clk) begin : drive_pop
    int run_left;
    bit pop_phase;
    if (rst) begin
      pop <= 1'b0;
      run_left = 0;
      pop_phase = 1'b0;
    end else if (holding) begin
      pop <= 1'b0;
    end else begin
      if (run_left == 0) begin
        pop_phase = !pop_phase;
        if (pop_phase)
          run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 24);
        else
          run_left = $urandom_range(0, MAX_STALL - 1);
      end else begin
        run_left--;
      end
      pop <= pop_phase;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("keyed_minute_bucket_aggregator_tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    kma_pkg::key_t key_a;
    kma_pkg::key_t ones_key;
    kma_pkg::key_t low_key;
    kma_pkg::key_t k;
    kma_pkg::key_t last_new_key;
    int            r;
    key_a = {32'h5A5A_0001, 12'h3C7, 4'd3, 5'd9, 5'd7, 6'd45};
    ones_key = '1;
    low_key = {32'h0, 12'h0, 4'd1, 5'd1, 5'd0, 6'd0};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: first key lands in entry 0
    queue_event(key_a, MAX_COST);
    queue_event(key_a, '0);
    // all-zero key has out-of-range month and day, matched as raw bits
    queue_event('0, '0);
    queue_event(ones_key, MAX_COST);
    queue_event(ones_key, MAX_COST);
    queue_event(ones_key ^ kma_pkg::key_t'(1), MAX_COST);
    queue_event(ones_key ^ (kma_pkg::key_t'(1) << (kma_pkg::KEY_W - 1)), 32'h0000_0001);
    queue_event({32'h0, 12'hFFF, 4'd12, 5'd31, 5'd23, 6'd59}, 32'h0000_0001);
    queue_event(low_key, '0);
    queue_event('0, 32'h0000_0001);
    // single field bits apart from the first key
    queue_event(key_a ^ (kma_pkg::key_t'(1) << 16), 32'h8000_0000);
    queue_event(key_a ^ (kma_pkg::key_t'(1) << 6), '0);
    queue_event(key_a ^ (kma_pkg::key_t'(1) << 52), 32'h7FFF_FFFF);
    queue_event(key_a, 32'h8000_0000);
    queue_event(low_key, '0);
    queue_event(ones_key ^ kma_pkg::key_t'(1), '0);
    wait_for_drain();

    // random mix of new keys, repeats and near misses, receiver held off at the start
    hold_arm <= 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40 || key_pool.size() == 0)
        k = fresh_key();
      else if (r < 50)
        k = flip_one_bit(key_pool[$urandom_range(0, key_pool.size() - 1)]);
      else
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      queue_event(k, pick_cost());
    end
    wait_for_drain();

    // tail: unseen keys mixed with repeats of the last new key and of earlier keys
    last_new_key = key_a;
    for (int i = 0; i < N_TAIL; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        k = unseen_key();
        last_new_key = k;
      end else if (r < 60) begin
        k = last_new_key;
      end else begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end
      queue_event(k, pick_cost());
    end
    wait_for_drain();

    // quiet period for stray result beats
    repeat (kma_pkg::ENTRIES + 16) @(posedge clk);
    if (expected_updates.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_updates.size()));
    if (error_count == 0)
      $display("keyed_minute_bucket_aggregator_tb: clean");
    else
      $display("keyed_minute_bucket_aggregator_tb: errors");
    $finish;
  end

endmodule
